[sv/sqrp_pkg.sv]
package sqrp_pkg;

    // Slot table geometry; the result's 10-bit pending count (up to 3 * SLOTS) caps it at 341 slots
    localparam int SLOTS       = 256;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int ID_BITS     = 32;
    localparam int HANDLE_BITS = 32;
    localparam int REF_BITS    = 9;
    localparam int NEW_DEPTH   = 2 * SLOTS;
    localparam int RS_DEPTH    = SLOTS;
    localparam int PEND_BITS   = 10;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    // Stream packing
    localparam int IN_ID_LSB     = 0;
    localparam int IN_HANDLE_LSB = ID_BITS;
    localparam int IN_DATA_BITS  = 64;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_DATA_BITS = 48;
    localparam int OUT_USED_BITS = 3 + HANDLE_BITS + PEND_BITS;

    typedef enum logic [1:0] {
        OP_PUSH_NEW    = 2'd0,
        OP_ERASE       = 2'd1,
        OP_PUSH_RESEND = 2'd2,
        OP_POP         = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_DELIVERED = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_STALE     = 3'd3,
        ST_FULL      = 3'd4,
        ST_MISS      = 3'd5
    } t_status;

    typedef struct packed {
        logic [ID_BITS-1:0]     id;
        logic [HANDLE_BITS-1:0] handle;
        logic [REF_BITS-1:0]    refs;
    } t_slot;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        t_slot                data;
    } t_slot_wr;

    typedef struct packed {
        t_op                    op;
        logic [ID_BITS-1:0]     id;
        logic [HANDLE_BITS-1:0] handle;
        logic [ID_BITS-1:0]     pid;
        logic                   drop;
        logic                   none;
        logic                   from_resend;
        logic [PEND_BITS-1:0]   pending;
    } t_item;

    typedef struct packed {
        t_status                status;
        logic [HANDLE_BITS-1:0] handle;
        logic                   from_resend;
        logic [PEND_BITS-1:0]   pending;
    } t_result;

endpackage

[sv/sqrp_fifo.sv]
module sqrp_fifo
    import sqrp_pkg::*;
#(
    parameter int DEPTH = NEW_DEPTH,
    parameter int W     = ID_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_wr_data,
    input  logic                       i_pop,
    output logic [W-1:0]               o_rd_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [W-1:0]  r_rd;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_head;
    logic [PW-1:0] n_tail;

    always_comb begin
        n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        n_tail = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    end

    // Storage; the head entry is read out on the pop edge
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_wr_data;
        end
        if (i_pop) begin
            r_rd <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= n_tail;
            end
            if (i_pop) begin
                r_head <= n_head;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd;
    assign o_count   = r_count;

endmodule

[sv/sqrp_slot_table.sv]
module sqrp_slot_table
    import sqrp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [SLOT_BITS-1:0] i_rd_addr,
    input  t_slot_wr             i_wr,
    output t_slot                o_rd_data,
    output logic                 o_busy
);

    t_slot                r_mem [SLOTS];
    t_slot                r_rd_data;
    logic [SLOT_BITS-1:0] r_rd_addr;
    t_slot_wr             r_fwd;
    logic                 r_clr_busy;
    logic [SLOT_BITS-1:0] r_clr_addr;
    t_slot_wr             wr;

    always_comb begin
        if (r_clr_busy) begin
            wr.en   = 1'b1;
            wr.addr = r_clr_addr;
            wr.data = '0;
        end else begin
            wr    = i_wr;
            wr.en = i_wr.en && i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            r_mem[wr.addr] <= wr.data;
        end
        if (i_en && !r_clr_busy) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Keep the write landing on the same edge as the read, so it can be bypassed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_fwd      <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == SLOT_BITS'(SLOTS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_en) begin
                r_fwd <= r_clr_busy ? '0 : wr;
            end
        end
    end

    assign o_rd_data = (r_fwd.en && r_fwd.addr == r_rd_addr) ? r_fwd.data : r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

[sv/send_queue_with_resend_priority.sv]
// Send queue with resend priority. Items (op in s_axis_tuser) push a new packet, push a
// resend, erase a reference or pop; every item gives exactly one result, in order, loaded
// into the output register or its skid entry. One item is taken per cycle while the skid
// entry is empty: FIFO bookkeeping is done on the accept edge, the slot table is addressed
// in stage 1 and its read-modify-write with a one-entry bypass is done in stage 2. A two-entry
// output register pair keeps taking items while one result waits. After reset the slot
// table is cleared one slot a cycle, all 256 slots, with s_axis_tready low.
module send_queue_with_resend_priority
    import sqrp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [31:0] packet_id, [63:32] data_handle
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [IN_USER_BITS-1:0]  s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [2:0] status, [34:3] out_handle, [44:35] pending, rest zero
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // [0] from_resend
    output logic                     m_axis_tuser
);

    localparam int NW_CW = $clog2(NEW_DEPTH + 1);
    localparam int RS_CW = $clog2(RS_DEPTH + 1);

    logic                   en;
    logic                   acc;
    logic                   tbl_busy;
    t_op                    in_op;
    logic [ID_BITS-1:0]     in_id;
    logic [HANDLE_BITS-1:0] in_handle;

    logic [NW_CW-1:0]   nw_count;
    logic [RS_CW-1:0]   rs_count;
    logic [ID_BITS-1:0] nw_rd;
    logic [ID_BITS-1:0] rs_rd;
    logic               nw_full;
    logic               rs_full;
    logic               push_nw;
    logic               push_rs;
    logic               pop_nw;
    logic               pop_rs;
    logic [PEND_BITS-1:0] cur_pend;

    t_item r_s1;
    logic  r_s1_valid;
    t_item n_s1;
    t_item r_s2;
    logic  r_s2_valid;
    t_item n_s2;
    logic [SLOT_BITS-1:0] rd_addr;

    t_slot    slot;
    t_slot_wr slot_wr;
    t_result  res;
    logic [REF_BITS-1:0] ref_dec;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;
    logic    take;

    assign en            = !r_skid_valid;
    assign s_axis_tready = en && !tbl_busy;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign in_op         = t_op'(s_axis_tuser);
    assign in_id         = s_axis_tdata[IN_ID_LSB +: ID_BITS];
    assign in_handle     = s_axis_tdata[IN_HANDLE_LSB +: HANDLE_BITS];

    // Queue bookkeeping on the accept edge; resend queue is served first
    always_comb begin
        nw_full  = (nw_count == NW_CW'(NEW_DEPTH));
        rs_full  = (rs_count == RS_CW'(RS_DEPTH));
        push_nw  = acc && in_op == OP_PUSH_NEW && !nw_full;
        push_rs  = acc && in_op == OP_PUSH_RESEND && !rs_full;
        pop_rs   = acc && in_op == OP_POP && rs_count != '0;
        pop_nw   = acc && in_op == OP_POP && rs_count == '0 && nw_count != '0;
        cur_pend = PEND_BITS'(nw_count) + PEND_BITS'(rs_count);

        n_s1.op          = in_op;
        n_s1.id          = in_id;
        n_s1.handle      = in_handle;
        n_s1.pid         = '0;
        n_s1.drop        = (in_op == OP_PUSH_NEW && nw_full) ||
                           (in_op == OP_PUSH_RESEND && rs_full);
        n_s1.none        = in_op == OP_POP && rs_count == '0 && nw_count == '0;
        n_s1.from_resend = pop_rs;
        if (push_nw || push_rs) begin
            n_s1.pending = cur_pend + 1'b1;
        end else if (pop_nw || pop_rs) begin
            n_s1.pending = cur_pend - 1'b1;
        end else begin
            n_s1.pending = cur_pend;
        end
    end

    sqrp_fifo #(
        .DEPTH (NEW_DEPTH),
        .W     (ID_BITS)
    ) u_new_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push_nw),
        .i_wr_data (in_id),
        .i_pop     (pop_nw),
        .o_rd_data (nw_rd),
        .o_count   (nw_count)
    );

    sqrp_fifo #(
        .DEPTH (RS_DEPTH),
        .W     (ID_BITS)
    ) u_resend_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push_rs),
        .i_wr_data (in_id),
        .i_pop     (pop_rs),
        .o_rd_data (rs_rd),
        .o_count   (rs_count)
    );

    // Stage 1: pick up the popped id and address the slot table
    always_comb begin
        n_s2     = r_s1;
        n_s2.pid = r_s1.from_resend ? rs_rd : nw_rd;
        if (r_s1.op == OP_POP) begin
            rd_addr = n_s2.pid[SLOT_BITS-1:0];
        end else begin
            rd_addr = r_s1.id[SLOT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= acc;
            r_s2_valid <= r_s1_valid;
        end
    end

    sqrp_slot_table u_slot_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_rd_addr (rd_addr),
        .i_wr      (slot_wr),
        .o_rd_data (slot),
        .o_busy    (tbl_busy)
    );

    // Stage 2: slot read-modify-write and result
    always_comb begin
        slot_wr.en       = 1'b0;
        slot_wr.data     = slot;
        res.status       = ST_DONE;
        res.handle       = '0;
        res.from_resend  = r_s2.from_resend;
        res.pending      = r_s2.pending;
        ref_dec          = (slot.refs != '0) ? slot.refs - 1'b1 : '0;
        if (r_s2.op == OP_POP) begin
            slot_wr.addr = r_s2.pid[SLOT_BITS-1:0];
        end else begin
            slot_wr.addr = r_s2.id[SLOT_BITS-1:0];
        end
        case (r_s2.op)
            OP_PUSH_NEW: begin
                if (r_s2.drop) begin
                    res.status = ST_FULL;
                end else begin
                    slot_wr.en          = r_s2_valid;
                    slot_wr.data.id     = r_s2.id;
                    slot_wr.data.handle = r_s2.handle;
                    slot_wr.data.refs   = REF_BITS'(1);
                end
            end
            OP_ERASE: begin
                if (r_s2.id == '0 || slot.id != r_s2.id) begin
                    res.status = ST_MISS;
                end else begin
                    slot_wr.en        = r_s2_valid;
                    slot_wr.data.refs = ref_dec;
                    if (ref_dec == '0) begin
                        slot_wr.data.id = '0;
                    end
                end
            end
            OP_PUSH_RESEND: begin
                if (r_s2.drop) begin
                    res.status = ST_FULL;
                end else begin
                    slot_wr.en = r_s2_valid;
                    if (slot.refs != REF_MAX) begin
                        slot_wr.data.refs = slot.refs + 1'b1;
                    end
                end
            end
            OP_POP: begin
                if (r_s2.none) begin
                    res.status = ST_EMPTY;
                end else if (r_s2.pid != '0 && slot.id == r_s2.pid) begin
                    res.status = ST_DELIVERED;
                    res.handle = slot.handle;
                end else begin
                    res.status = ST_STALE;
                end
            end
            default: begin
                res.status = ST_DONE;
            end
        endcase
    end

    // Output register with one skid entry
    assign take = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (r_s2_valid) begin
            if (!r_out_valid || take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_BITS - OUT_USED_BITS){1'b0}},
                            r_out.pending, r_out.handle, r_out.status};
    assign m_axis_tuser  = r_out.from_resend;

endmodule
